### hw/rtl/bcws_pkg.sv
// ----------------------------------------------------------------------------
// bcws_pkg
// shared types and constants for the boxcar window sum block
// ----------------------------------------------------------------------------
package bcws_pkg;

    // result value width, sums wrap to this width
    localparam int VALUE_W   = 22;
    // window length register and fill count width
    localparam int COUNT_W   = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_raw;
        logic                      too_short;
        logic                      run_end;
    } result_t;

endpackage

### hw/rtl/bcws_ram.sv
// ----------------------------------------------------------------------------
// bcws_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bcws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/bcws_out_reg.sv
// ----------------------------------------------------------------------------
// bcws_out_reg
// result holding register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module bcws_out_reg
    import bcws_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  result_t                   result,
    output logic                      free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value,
    output logic                      m_is_raw,
    output logic                      m_too_short,
    output logic                      m_run_end
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    // slot can take a new item when empty or being drained this cycle
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = result;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid     = valid_reg;
    assign m_value     = data_reg.value;
    assign m_is_raw    = data_reg.is_raw;
    assign m_too_short = data_reg.too_short;
    assign m_run_end   = data_reg.run_end;

endmodule

### hw/rtl/boxcar_window_sum.sv
// ----------------------------------------------------------------------------
// boxcar_window_sum
// moving boxcar sum over records of signed samples, ring buffer in block ram
// ----------------------------------------------------------------------------
// an item's first result is loaded in S_OUT, after the S_SUM state, once the
// result slot is free; a new item is taken only back in S_IDLE, after every
// result of the last one is loaded; at record end each raw tail sample is
//   read in S_TRD and emitted in S_TOUT, after the held back first sum if any,
//   paced by the single ram read port and one result slot
// reset: synchronous active low; clears window length, running sum, fill count
//   and ring pointer; the ring ram contents are not cleared
module boxcar_window_sum
    import bcws_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration
    input  logic                          cfg_wr_en,
    input  logic [COUNT_W-1:0]            cfg_wr_data,

    // sample channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_record_end,

    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_W-1:0]     m_value,
    output logic                          m_is_raw,
    output logic                          m_too_short,
    output logic                          m_run_end
);

    // ring depth is the window max rounded up to a power of two
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int RING_DEPTH = 1 << PTR_W;
    localparam logic [COUNT_W-1:0] WIN_MAX_C = COUNT_W'(WINDOW_MAX);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
    localparam logic [2:0] S_SUM  = 3'd1;  // oldest sample back from ram, form sum
    localparam logic [2:0] S_OUT  = 3'd2;  // emit results from registers
    localparam logic [2:0] S_TRD  = 3'd3;  // read one tail sample
    localparam logic [2:0] S_TOUT = 3'd4;  // emit tail sample from ram data

    // which result S_OUT emits next
    localparam logic [2:0] PH_PASS = 3'd0;  // passthrough sample
    localparam logic [2:0] PH_ERR  = 3'd1;  // record too short
    localparam logic [2:0] PH_OLD  = 3'd2;  // first full window sum
    localparam logic [2:0] PH_NEW  = 3'd3;  // sum ending at this item
    localparam logic [2:0] PH_LAST = 3'd4;  // final raw sample of the record

    logic [2:0]                   state_reg, state_next;
    logic [2:0]                   phase_reg, phase_next;
    logic [COUNT_W-1:0]           window_length_reg, window_length_next;

    // record state
    logic signed [VALUE_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]           fill_reg, fill_next;
    logic [PTR_W-1:0]             ptr_reg, ptr_next;

    // per item working registers
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          last_reg, last_next;
    logic [COUNT_W-1:0]            n_reg, n_next;
    logic [COUNT_W-1:0]            c_reg, c_next;
    logic signed [VALUE_W-1:0]     old_reg, old_next;
    logic signed [VALUE_W-1:0]     new_reg, new_next;
    logic [PTR_W-1:0]              base_reg, base_next;
    logic [COUNT_W-1:0]            age_reg, age_next;

    // ram port
    logic                          ram_wr_en;
    logic                          ram_rd_en;
    logic [PTR_W-1:0]              ram_rd_addr;
    logic [SAMPLE_BITS-1:0]        ram_rd_data;

    // result slot
    logic                          out_load;
    logic                          out_free;
    result_t                       out_result;

    logic [COUNT_W-1:0]            n_clamped;
    logic signed [VALUE_W-1:0]     x_ext;
    logic signed [VALUE_W-1:0]     rd_ext;
    logic signed [VALUE_W-1:0]     drop;
    logic signed [VALUE_W-1:0]     sum_calc;

    assign s_ready   = (state_reg == S_IDLE);
    assign n_clamped = (window_length_reg > WIN_MAX_C) ? WIN_MAX_C : window_length_reg;

    // sign extend (or wrap for wide samples) into the sum width
    assign x_ext  = VALUE_W'(x_reg);
    assign rd_ext = VALUE_W'($signed(ram_rd_data));

    // the sample leaving the window, only once the window is full
    assign drop     = (c_reg >= n_reg) ? rd_ext : '0;
    assign sum_calc = sum_reg + x_ext - drop;

    always_comb begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        window_length_next = window_length_reg;
        sum_next           = sum_reg;
        fill_next          = fill_reg;
        ptr_next           = ptr_reg;
        x_next             = x_reg;
        last_next          = last_reg;
        n_next             = n_reg;
        c_next             = c_reg;
        old_next           = old_reg;
        new_next           = new_reg;
        base_next          = base_reg;
        age_next           = age_reg;
        ram_wr_en          = 1'b0;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = ptr_reg - n_clamped[PTR_W-1:0];
        out_load           = 1'b0;
        out_result         = '0;

        if (cfg_wr_en) begin
            window_length_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                // fetch the sample n places back while latching the item
                if (s_valid) begin
                    x_next     = s_sample;
                    last_next  = s_record_end;
                    n_next     = n_clamped;
                    c_next     = fill_reg;
                    ram_rd_en  = 1'b1;
                    state_next = S_SUM;
                end
            end

            S_SUM: begin
                old_next  = sum_reg;
                new_next  = sum_calc;
                base_next = ptr_reg;
                age_next  = n_reg - COUNT_W'(2);
                if (n_reg == '0) begin
                    // passthrough drops any partial record
                    phase_next = PH_PASS;
                    state_next = S_OUT;
                    sum_next   = '0;
                    fill_next  = '0;
                    ptr_next   = '0;
                end else if (last_reg) begin
                    if ((c_reg < n_reg) || ((c_reg == n_reg) && (n_reg == WIN_MAX_C))) begin
                        phase_next = PH_ERR;
                    end else if (c_reg == n_reg) begin
                        phase_next = PH_OLD;
                    end else begin
                        phase_next = PH_NEW;
                    end
                    state_next = S_OUT;
                    sum_next   = '0;
                    fill_next  = '0;
                    ptr_next   = '0;
                end else begin
                    // store the sample and advance the record
                    ram_wr_en = 1'b1;
                    ptr_next  = ptr_reg + PTR_W'(1);
                    sum_next  = sum_calc;
                    fill_next = (c_reg == COUNT_MAX) ? COUNT_MAX : c_reg + COUNT_W'(1);
                    if (c_reg == n_reg) begin
                        phase_next = PH_OLD;
                        state_next = S_OUT;
                    end else if (c_reg > n_reg) begin
                        phase_next = PH_NEW;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    unique case (phase_reg)
                        PH_PASS: begin
                            out_result = '{value: x_ext, is_raw: 1'b1,
                                           too_short: 1'b0, run_end: last_reg};
                            state_next = S_IDLE;
                        end
                        PH_ERR: begin
                            out_result = '{value: '0, is_raw: 1'b0,
                                           too_short: 1'b1, run_end: 1'b1};
                            state_next = S_IDLE;
                        end
                        PH_OLD: begin
                            out_result = '{value: old_reg, is_raw: 1'b0,
                                           too_short: 1'b0, run_end: 1'b0};
                            phase_next = PH_NEW;
                        end
                        PH_NEW: begin
                            out_result = '{value: new_reg, is_raw: 1'b0, too_short: 1'b0,
                                           run_end: last_reg && (n_reg == COUNT_W'(1))};
                            if (!last_reg || (n_reg == COUNT_W'(1))) begin
                                state_next = S_IDLE;
                            end else if (n_reg == COUNT_W'(2)) begin
                                phase_next = PH_LAST;
                            end else begin
                                state_next = S_TRD;
                            end
                        end
                        PH_LAST: begin
                            out_result = '{value: x_ext, is_raw: 1'b1,
                                           too_short: 1'b0, run_end: 1'b1};
                            state_next = S_IDLE;
                        end
                        default: begin
                            out_load   = 1'b0;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_TRD: begin
                // tail samples oldest first, n-2 places back down to one
                ram_rd_en   = 1'b1;
                ram_rd_addr = base_reg - age_reg[PTR_W-1:0];
                state_next  = S_TOUT;
            end

            S_TOUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_result = '{value: rd_ext, is_raw: 1'b1,
                                   too_short: 1'b0, run_end: 1'b0};
                    age_next   = age_reg - COUNT_W'(1);
                    if (age_reg == COUNT_W'(1)) begin
                        phase_next = PH_LAST;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_TRD;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            phase_reg         <= PH_PASS;
            window_length_reg <= '0;
            sum_reg           <= '0;
            fill_reg          <= '0;
            ptr_reg           <= '0;
        end else begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            window_length_reg <= window_length_next;
            sum_reg           <= sum_next;
            fill_reg          <= fill_next;
            ptr_reg           <= ptr_next;
        end
        x_reg    <= x_next;
        last_reg <= last_next;
        n_reg    <= n_next;
        c_reg    <= c_next;
        old_reg  <= old_next;
        new_reg  <= new_next;
        base_reg <= base_next;
        age_reg  <= age_next;
    end

    // sample ring, written at the record pointer
    bcws_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (x_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result slot lets the next item in while a result waits
    bcws_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .result      (out_result),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_is_raw    (m_is_raw),
        .m_too_short (m_too_short),
        .m_run_end   (m_run_end)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for boxcar_window_sum: a directed table of samples,
// then random records under several idle patterns, each result checked in
// order against an in-bench prediction of sums, raw tails and error results
// ----------------------------------------------------------------------------
module tb
    import bcws_pkg::*;
;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_W      = 16;
    // cycles to let the block settle once nothing is outstanding
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 25;

    typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_mode_t;

    // one row of the directed table; typed rows carry their single result
    typedef struct packed {
        logic [COUNT_W-1:0]        window;
        logic signed [15:0]        sample;
        logic                      last;
        logic                      typed;
        logic signed [VALUE_W-1:0] value;
        logic                      is_raw;
        logic                      too_short;
        logic                      run_end;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       cfg_wr_en    = 1'b0;
    logic [COUNT_W-1:0]         cfg_wr_data  = '0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample     = '0;
    logic                       s_record_end = 1'b0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [VALUE_W-1:0]  m_value;
    logic                       m_is_raw;
    logic                       m_too_short;
    logic                       m_run_end;

    always #2 aclk = ~aclk;

    boxcar_window_sum #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_W)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_record_end (s_record_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_is_raw     (m_is_raw),
        .m_too_short  (m_too_short),
        .m_run_end    (m_run_end)
    );

    // ------------------------------------------------------------------------
    // bench-side copy of the block state, as it stands after reset
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0] window_q = '0;
    logic [15:0]        ring_q [64];
    logic [VALUE_W-1:0] sum_q    = '0;
    logic [COUNT_W-1:0] fill_q   = '0;
    logic [5:0]         ptr_q    = '0;

    // results caused by the latest sample, and all results still to arrive
    result_t step_results [$];
    result_t pending_results [$];

    // traffic shaping knobs, changed by the stimulus between phases
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int pause_pct          = 0;
    int rx_hold_request    = 0;
    int rx_hold_left       = 0;

    int samples_sent   = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // extremes, every window class, and the special cases by name
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // passthrough at the reset window, both sample extremes
        '{0,    32767, 0, 1,  32767, 1, 0, 0},
        '{0,   -32768, 1, 1, -32768, 1, 0, 1},
        '{0,        0, 0, 1,      0, 1, 0, 0},
        // window of one: a record of one sample is too short
        '{1,        5, 1, 1,      0, 0, 1, 1},
        '{1,    32767, 0, 0,      0, 0, 0, 0},
        '{1,    32767, 0, 0,      0, 0, 0, 0},
        '{1,   -32768, 1, 0,      0, 0, 0, 0},
        // record exactly as long as the window is too short
        '{3,      100, 0, 0,      0, 0, 0, 0},
        '{3,     -200, 0, 0,      0, 0, 0, 0},
        '{3,      300, 1, 1,      0, 0, 1, 1},
        // window shrinks in the middle of a record, sum is not rebuilt
        '{3,        7, 0, 0,      0, 0, 0, 0},
        '{3,       -9, 0, 0,      0, 0, 0, 0},
        '{2,       11, 0, 0,      0, 0, 0, 0},
        '{2,       13, 1, 0,      0, 0, 0, 0},
        // passthrough item drops a partial record
        '{5,   -32768, 0, 0,      0, 0, 0, 0},
        '{5,   -32768, 0, 0,      0, 0, 0, 0},
        '{0,     1234, 1, 1,   1234, 1, 0, 1},
        // window above the maximum acts as the maximum
        '{127,     42, 0, 0,      0, 0, 0, 0},
        '{127,    -42, 1, 1,      0, 0, 1, 1},
        // smallest and largest two-sample sums
        '{2,   -32768, 0, 0,      0, 0, 0, 0},
        '{2,   -32768, 0, 0,      0, 0, 0, 0},
        '{2,   -32768, 1, 0,      0, 0, 0, 0},
        '{2,    32767, 0, 0,      0, 0, 0, 0},
        '{2,    32767, 0, 0,      0, 0, 0, 0},
        '{2,    32767, 1, 0,      0, 0, 0, 0}
    };

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic void note_result(input logic [VALUE_W-1:0] v, input logic raw,
                                        input logic short_rec, input logic end_rec);
        result_t r;
        r.value     = v;
        r.is_raw    = raw;
        r.too_short = short_rec;
        r.run_end   = end_rec;
        step_results.push_back(r);
    endfunction

    function automatic void clear_record();
        sum_q  = '0;
        fill_q = '0;
        ptr_q  = '0;
    endfunction

    // sample written age slots back, sign-extended to the sum width
    function automatic logic [VALUE_W-1:0] ring_at(input int age);
        logic [5:0] slot;
        slot = ptr_q - 6'(age);
        return {{(VALUE_W-16){ring_q[slot][15]}}, ring_q[slot]};
    endfunction

    function automatic void predict_window_sums(input logic [15:0] smp, input logic last);
        int                 n;
        int                 c;
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] old_sum;
        logic [VALUE_W-1:0] new_sum;
        n       = (window_q > WINDOW_MAX) ? WINDOW_MAX : int'(window_q);
        c       = int'(fill_q);
        x       = {{(VALUE_W-16){smp[15]}}, smp};
        old_sum = sum_q;
        step_results.delete();

        // passthrough, any partial record is dropped
        if (n == 0) begin
            note_result(x, 1'b1, 1'b0, last);
            clear_record();
            return;
        end

        new_sum = old_sum + x;
        if (c >= n)
            new_sum = new_sum - ring_at(n);

        if (last) begin
            // too short, or a full window at the maximum that cannot drain
            if (c + 1 <= n || (c == n && n == WINDOW_MAX)) begin
                note_result('0, 1'b0, 1'b1, 1'b1);
                clear_record();
                return;
            end
            if (c == n)
                note_result(old_sum, 1'b0, 1'b0, 1'b0);
            note_result(new_sum, 1'b0, 1'b0, n == 1);
            if (n >= 2) begin
                for (int age = n - 2; age >= 1; age--)
                    note_result(ring_at(age), 1'b1, 1'b0, 1'b0);
                note_result(x, 1'b1, 1'b0, 1'b1);
            end
            clear_record();
            return;
        end

        // first sum is held back until the record is known to be long enough
        if (c == n) begin
            note_result(old_sum, 1'b0, 1'b0, 1'b0);
            note_result(new_sum, 1'b0, 1'b0, 1'b0);
        end else if (c > n) begin
            note_result(new_sum, 1'b0, 1'b0, 1'b0);
        end

        ring_q[ptr_q] = smp;
        ptr_q         = ptr_q + 6'd1;
        sum_q         = new_sum;
        fill_q        = (fill_q < COUNT_MAX) ? fill_q + 1'b1 : COUNT_MAX;
    endfunction

    // ------------------------------------------------------------------------
    // sample channel
    // ------------------------------------------------------------------------
    // offers one item after a random gap and returns at the edge that takes it
    task automatic send_sample(input logic [15:0] smp, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample     <= smp;
        s_record_end <= last;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        samples_sent++;
    endtask

    task automatic accept_sample(input logic [15:0] smp, input logic last);
        send_sample(smp, last);
        predict_window_sums(smp, last);
        foreach (step_results[k])
            pending_results.push_back(step_results[k]);
    endtask

    // stop offering, let every expected result arrive, then let the block settle
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input logic [COUNT_W-1:0] w);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        window_q   = w;
    endtask

    task automatic send_record(input int len, input fill_mode_t mode);
        logic [15:0] smp;
        int unsigned r;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            case (mode)
                FILL_MAX: smp = 16'h7fff;
                FILL_MIN: smp = 16'h8000;
                default: begin
                    // lean on the extremes, otherwise any bit pattern
                    if (r < 10)      smp = 16'h7fff;
                    else if (r < 20) smp = 16'h8000;
                    else if (r < 25) smp = 16'h0000;
                    else             smp = 16'($urandom);
                end
            endcase
            // sender holds off mid-record until everything owed has come out
            if (k == len / 2 && $urandom_range(99) < pause_pct)
                wait_quiet();
            accept_sample(smp, k == len - 1);
        end
    endtask

    // records of random content, mostly long enough to give sums, some too short
    task automatic run_phase(input logic [COUNT_W-1:0] w, input int items,
                             input int tx_idle, input int rx_stall);
        int          n;
        int          len;
        int          sent;
        int unsigned r;
        set_window(w);
        sender_idle_pct    = tx_idle;
        receiver_stall_pct = rx_stall;
        n    = (w > WINDOW_MAX) ? WINDOW_MAX : int'(w);
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(99);
            if (n == 0)      len = $urandom_range(1, 6);
            else if (r < 15) len = $urandom_range(1, n);
            else if (r < 25) len = n + 1;
            else             len = n + $urandom_range(2, 12);
            send_record(len, FILL_RANDOM);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // result channel: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // every taken result must match the oldest one still owed
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result %0d not expected: value %0d raw %b short %b end %b",
                             results_seen, m_value, m_is_raw, m_too_short, m_run_end);
            end else begin
                want = pending_results.pop_front();
                if (m_value !== want.value || m_is_raw !== want.is_raw ||
                    m_too_short !== want.too_short || m_run_end !== want.run_end) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result %0d: want %0d/%b/%b/%b got %0d/%b/%b/%b",
                                 results_seen, $signed(want.value), want.is_raw,
                                 want.too_short, want.run_end, m_value, m_is_raw,
                                 m_too_short, m_run_end);
                end
            end
        end
    end

    // a run that hangs ends here
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, window rewritten whenever a row asks for another
        foreach (directed_rows[i]) begin
            if (directed_rows[i].window != window_q)
                set_window(directed_rows[i].window);
            if (directed_rows[i].typed) begin
                send_sample(directed_rows[i].sample, directed_rows[i].last);
                // keep the state in step, the row itself gives the result
                predict_window_sums(directed_rows[i].sample, directed_rows[i].last);
                pending_results.push_back({directed_rows[i].value, directed_rows[i].is_raw,
                                           directed_rows[i].too_short,
                                           directed_rows[i].run_end});
            end else begin
                accept_sample(directed_rows[i].sample, directed_rows[i].last);
            end
        end

        // random records, one idle pattern per phase
        run_phase(COUNT_W'(4), 15, 0, 0);
        run_phase(COUNT_W'(0), 10, 49, 0);
        pause_pct = 100;
        run_phase(COUNT_W'($urandom_range(1, 16)), 15, 0, 49);
        pause_pct = 0;

        // receiver holds off while a long record keeps coming, block backs up
        set_window(COUNT_W'(8));
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rx_hold_request    = 400;
        send_record(20, FILL_RANDOM);

        // largest window: a full-scale record one longer than it cannot drain,
        // then the window above the maximum gives the smallest sums
        set_window(COUNT_W'(WINDOW_MAX));
        sender_idle_pct    = 18;
        receiver_stall_pct = 18;
        send_record(WINDOW_MAX + 1, FILL_MAX);
        set_window(COUNT_W'(127));
        send_record(WINDOW_MAX + 2, FILL_MIN);

        wait_quiet();
        $display("%0d samples in, %0d results out, windows 0 to 127 under four idle patterns",
                 samples_sent, results_seen);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
